@@ rtl/ist_pkg.sv @@
`default_nettype none

package ist_pkg;

   localparam int DATA_WIDTH       = 64;
   localparam int MODE_WIDTH       = 2;
   localparam int SAMPLE_DEPTH_DEF = 8;
   localparam int AVG_SHIFT        = 3;

   localparam logic [MODE_WIDTH-1:0] MODE_BEGIN  = 2'd0;
   localparam logic [MODE_WIDTH-1:0] MODE_END    = 2'd1;
   localparam logic [MODE_WIDTH-1:0] MODE_CLEAR  = 2'd2;
   localparam logic [MODE_WIDTH-1:0] MODE_UNUSED = 2'd3;

   typedef logic [DATA_WIDTH-1:0] data_type;

   typedef struct packed {
      logic [MODE_WIDTH-1:0] mode;
      data_type              time_stamp;
      data_type              cycle_stamp;
   } req_word_type;

   typedef struct packed {
      data_type cur_time_delta;
      data_type cur_cycle_delta;
      data_type avg_time_delta;
      data_type avg_cycle_delta;
      data_type peak_time_delta;
      data_type peak_cycle_delta;
   } rsp_word_type;

   typedef struct packed {
      logic begin_op;
      logic end_op;
      logic clear_op;
   } ist_ctl_type;

endpackage

`default_nettype wire

@@ rtl/ist_if.sv @@
`default_nettype none

interface ist_req_if;
   logic                            valid;
   logic                            ready;
   logic [ist_pkg::MODE_WIDTH-1:0]  mode;
   logic [ist_pkg::DATA_WIDTH-1:0]  time_stamp;
   logic [ist_pkg::DATA_WIDTH-1:0]  cycle_stamp;

   modport source (output valid, output mode, output time_stamp, output cycle_stamp,
                   input ready);
   modport sink   (input valid, input mode, input time_stamp, input cycle_stamp,
                   output ready);
endinterface

interface ist_rsp_if;
   logic                            valid;
   logic                            ready;
   logic [ist_pkg::DATA_WIDTH-1:0]  cur_time_delta;
   logic [ist_pkg::DATA_WIDTH-1:0]  cur_cycle_delta;
   logic [ist_pkg::DATA_WIDTH-1:0]  avg_time_delta;
   logic [ist_pkg::DATA_WIDTH-1:0]  avg_cycle_delta;
   logic [ist_pkg::DATA_WIDTH-1:0]  peak_time_delta;
   logic [ist_pkg::DATA_WIDTH-1:0]  peak_cycle_delta;

   modport source (output valid, output cur_time_delta, output cur_cycle_delta,
                   output avg_time_delta, output avg_cycle_delta,
                   output peak_time_delta, output peak_cycle_delta,
                   input ready);
   modport sink   (input valid, input cur_time_delta, input cur_cycle_delta,
                   input avg_time_delta, input avg_cycle_delta,
                   input peak_time_delta, input peak_cycle_delta,
                   output ready);
endinterface

`default_nettype wire

@@ rtl/ist_ring.sv @@
`default_nettype none

module ist_ring #(
   parameter int SampleDepth = ist_pkg::SAMPLE_DEPTH_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  ist_pkg::ist_ctl_type ctl,
   input  ist_pkg::data_type    wr_time,
   input  ist_pkg::data_type    wr_cycle,
   output ist_pkg::data_type    old_time,
   output ist_pkg::data_type    old_cycle
);
   import ist_pkg::*;

   localparam int PosWidth = (SampleDepth > 1) ? $clog2(SampleDepth) : 1;
   localparam logic [PosWidth-1:0] LastPos = PosWidth'(SampleDepth - 1);

   logic [2*DATA_WIDTH-1:0] mem [SampleDepth];
   logic [2*DATA_WIDTH-1:0] rd_ff;
   logic [SampleDepth-1:0]  valid_ff;
   logic [PosWidth-1:0]     pos_ff;
   logic [PosWidth-1:0]     pos_in;

   always_comb begin
      pos_in = pos_ff;
      if (ctl.end_op) begin
         pos_in = (pos_ff == LastPos) ? '0 : pos_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
      end else begin
         pos_ff <= pos_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || ctl.clear_op) begin
         valid_ff <= '0;
      end else if (ctl.end_op) begin
         valid_ff[pos_ff] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.end_op) begin
         mem[pos_ff] <= {wr_time, wr_cycle};
      end
      rd_ff <= mem[pos_in];
   end

   assign old_time  = valid_ff[pos_ff] ? rd_ff[2*DATA_WIDTH-1:DATA_WIDTH] : '0;
   assign old_cycle = valid_ff[pos_ff] ? rd_ff[DATA_WIDTH-1:0] : '0;

endmodule

`default_nettype wire

@@ rtl/ist_stats.sv @@
`default_nettype none

module ist_stats (
   input  logic                  clock,
   input  logic                  reset,
   input  ist_pkg::ist_ctl_type  ctl,
   input  ist_pkg::data_type     time_stamp,
   input  ist_pkg::data_type     cycle_stamp,
   input  ist_pkg::data_type     old_time,
   input  ist_pkg::data_type     old_cycle,
   output ist_pkg::data_type     wall_span,
   output ist_pkg::data_type     cur_cycle,
   output ist_pkg::rsp_word_type result
);
   import ist_pkg::*;

   data_type start_time_ff;
   data_type start_cycle_ff;
   data_type time_sum_ff;
   data_type cycle_sum_ff;
   data_type time_peak_ff;
   data_type cycle_peak_ff;
   data_type time_sum_in;
   data_type cycle_sum_in;
   data_type time_peak_in;
   data_type cycle_peak_in;

   assign wall_span = time_stamp - start_time_ff;
   assign cur_cycle = cycle_stamp - start_cycle_ff;

   assign time_sum_in   = time_sum_ff - old_time + wall_span;
   assign cycle_sum_in  = cycle_sum_ff - old_cycle + cur_cycle;
   assign time_peak_in  = (wall_span > time_peak_ff) ? wall_span : time_peak_ff;
   assign cycle_peak_in = (cur_cycle > cycle_peak_ff) ? cur_cycle : cycle_peak_ff;

   always_comb begin
      result.cur_time_delta   = wall_span;
      result.cur_cycle_delta  = cur_cycle;
      result.avg_time_delta   = time_sum_in >> AVG_SHIFT;
      result.avg_cycle_delta  = cycle_sum_in >> AVG_SHIFT;
      result.peak_time_delta  = time_peak_in;
      result.peak_cycle_delta = cycle_peak_in;
   end

   always_ff @(posedge clock) begin
      if (reset || ctl.clear_op) begin
         start_time_ff  <= '0;
         start_cycle_ff <= '0;
         time_sum_ff    <= '0;
         cycle_sum_ff   <= '0;
         time_peak_ff   <= '0;
         cycle_peak_ff  <= '0;
      end else if (ctl.begin_op) begin
         start_time_ff  <= time_stamp;
         start_cycle_ff <= cycle_stamp;
      end else if (ctl.end_op) begin
         time_sum_ff    <= time_sum_in;
         cycle_sum_ff   <= cycle_sum_in;
         time_peak_ff   <= time_peak_in;
         cycle_peak_ff  <= cycle_peak_in;
      end
   end

endmodule

`default_nettype wire

@@ rtl/interval_stats_tracker_core.sv @@
// Interval statistics tracker.
// req_chan takes one word per cycle: mode (begin, end, clear) plus a wall-time
// stamp and a cycle stamp. Begin latches both stamps, clear zeroes stamps, sums,
// peaks and the sample ring. End takes both deltas against the latched stamps,
// replaces the oldest ring entry and returns one word on rsp_chan: current
// deltas, window sums shifted right by AVG_SHIFT, and running peaks.
// Begin, clear and the unused mode code return nothing.
// An accepted end word passes the input register, then the result register,
// before rsp_chan shows it. Throughput is one word per cycle while no end word
// waits on a stalled rsp_chan; the ring is a SampleDepth-entry memory with one
// registered read port whose address runs one entry ahead, so back-to-back end
// words never wait on it. Reset clears stamps, sums, peaks, ring position and
// the ring valid bits; the block accepts words in the first cycle after reset.
// When rsp_chan stalls, the result word holds; begin and clear words keep
// flowing, the next end word waits in the input register and req_chan.ready
// drops until the result word is taken.
`default_nettype none

module interval_stats_tracker_core #(
   parameter int SampleDepth = ist_pkg::SAMPLE_DEPTH_DEF
) (
   input  logic      clock,
   input  logic      reset,
   ist_req_if.sink   req_chan,
   ist_rsp_if.source rsp_chan
);
   import ist_pkg::*;

   logic         in_valid_ff;
   req_word_type in_word_ff;
   logic         out_valid_ff;
   logic         out_valid_in;
   rsp_word_type out_word_ff;
   rsp_word_type result;
   logic         advance;
   logic         is_end;
   ist_ctl_type  ctl;
   data_type     old_time;
   data_type     old_cycle;
   data_type     wall_span;
   data_type     cur_cycle;

   assign is_end  = (in_word_ff.mode == MODE_END);
   assign advance = in_valid_ff && (!is_end || !out_valid_ff || rsp_chan.ready);

   always_comb begin
      ctl.begin_op = advance && (in_word_ff.mode == MODE_BEGIN);
      ctl.end_op   = advance && is_end;
      ctl.clear_op = advance && (in_word_ff.mode == MODE_CLEAR);
   end

   assign req_chan.ready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_chan.ready) begin
         in_valid_ff <= req_chan.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_chan.ready && req_chan.valid) begin
         in_word_ff.mode        <= req_chan.mode;
         in_word_ff.time_stamp  <= req_chan.time_stamp;
         in_word_ff.cycle_stamp <= req_chan.cycle_stamp;
      end
   end

   ist_ring #(
      .SampleDepth(SampleDepth)
   ) u_ring (
      .clock    (clock),
      .reset    (reset),
      .ctl      (ctl),
      .wr_time  (wall_span),
      .wr_cycle (cur_cycle),
      .old_time (old_time),
      .old_cycle(old_cycle)
   );

   ist_stats u_stats (
      .clock      (clock),
      .reset      (reset),
      .ctl        (ctl),
      .time_stamp (in_word_ff.time_stamp),
      .cycle_stamp(in_word_ff.cycle_stamp),
      .old_time   (old_time),
      .old_cycle  (old_cycle),
      .wall_span  (wall_span),
      .cur_cycle  (cur_cycle),
      .result     (result)
   );

   always_comb begin
      out_valid_in = out_valid_ff && !rsp_chan.ready;
      if (ctl.end_op) begin
         out_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.end_op) begin
         out_word_ff <= result;
      end
   end

   assign rsp_chan.valid            = out_valid_ff;
   assign rsp_chan.cur_time_delta   = out_word_ff.cur_time_delta;
   assign rsp_chan.cur_cycle_delta  = out_word_ff.cur_cycle_delta;
   assign rsp_chan.avg_time_delta   = out_word_ff.avg_time_delta;
   assign rsp_chan.avg_cycle_delta  = out_word_ff.avg_cycle_delta;
   assign rsp_chan.peak_time_delta  = out_word_ff.peak_time_delta;
   assign rsp_chan.peak_cycle_delta = out_word_ff.peak_cycle_delta;

   a_end_loads_out: assert property (@(posedge clock) disable iff (reset)
      ctl.end_op |=> out_valid_ff)
      else $error("end word did not load result register");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      ctl.end_op |-> (!out_valid_ff || rsp_chan.ready))
      else $error("end word overwrote a pending result");

   a_peak_bounds_cur: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> (out_word_ff.peak_time_delta >= out_word_ff.cur_time_delta &&
                        out_word_ff.peak_cycle_delta >= out_word_ff.cur_cycle_delta))
      else $error("peak below current delta");

   a_ctl_needs_word: assert property (@(posedge clock) disable iff (reset)
      !in_valid_ff |-> !(ctl.begin_op || ctl.end_op || ctl.clear_op))
      else $error("operation without a held word");

endmodule

`default_nettype wire

@@ bench/interval_stats_tracker_core_test.sv @@
`default_nettype none

module interval_stats_tracker_core_test;
   import ist_pkg::*;

   localparam int RING_DEPTH  = SAMPLE_DEPTH_DEF;
   localparam int PHASE_WORDS = 317;
   localparam int CYCLE_LIMIT = 300000;
   localparam int DRAIN_CYCLES = 12;

   logic clock;
   logic reset;

   ist_req_if req_chan ();
   ist_rsp_if rsp_chan ();

   interval_stats_tracker_core #(
      .SampleDepth(RING_DEPTH)
   ) dut (
      .clock   (clock),
      .reset   (reset),
      .req_chan(req_chan),
      .rsp_chan(rsp_chan)
   );

   req_word_type pending_words[$];
   rsp_word_type expected_stats[$];

   int send_idle_pct;
   int recv_idle_pct;
   int error_count;
   int cycle_count;
   int phase_word_count;

   data_type held_time;
   data_type held_cycles;
   data_type time_deltas[RING_DEPTH];
   data_type cycle_deltas[RING_DEPTH];
   data_type time_sum;
   data_type cycle_sum;
   data_type time_max;
   data_type cycle_max;
   int       slot;

   always begin
      clock = 1'b1;
      #6;
      clock = 1'b0;
      #6;
   end

   task automatic zero_stats();
      held_time   = '0;
      held_cycles = '0;
      time_sum    = '0;
      cycle_sum   = '0;
      time_max    = '0;
      cycle_max   = '0;
      for (int i = 0; i < RING_DEPTH; i++) begin
         time_deltas[i]  = '0;
         cycle_deltas[i] = '0;
      end
   endtask

   task automatic track_interval(input req_word_type w);
      rsp_word_type stats;
      data_type     wall_span;
      data_type     cycle_delta;
      case (w.mode)
         MODE_BEGIN: begin
            held_time   = w.time_stamp;
            held_cycles = w.cycle_stamp;
         end
         MODE_CLEAR: begin
            zero_stats();
         end
         MODE_END: begin
            wall_span   = w.time_stamp - held_time;
            cycle_delta = w.cycle_stamp - held_cycles;
            time_sum  = time_sum - time_deltas[slot] + wall_span;
            cycle_sum = cycle_sum - cycle_deltas[slot] + cycle_delta;
            time_deltas[slot]  = wall_span;
            cycle_deltas[slot] = cycle_delta;
            slot = (slot + 1) % RING_DEPTH;
            if (wall_span > time_max) time_max = wall_span;
            if (cycle_delta > cycle_max) cycle_max = cycle_delta;
            stats.cur_time_delta   = wall_span;
            stats.cur_cycle_delta  = cycle_delta;
            stats.avg_time_delta   = time_sum >> AVG_SHIFT;
            stats.avg_cycle_delta  = cycle_sum >> AVG_SHIFT;
            stats.peak_time_delta  = time_max;
            stats.peak_cycle_delta = cycle_max;
            expected_stats.push_back(stats);
         end
         default: begin
         end
      endcase
   endtask

   task automatic report_mismatch(input string what, input data_type got, input data_type want);
      $display("mismatch on %s: got %h, want %h", what, got, want);
      error_count++;
   endtask

   task automatic check_stats(input rsp_word_type got);
      rsp_word_type want;
      if (expected_stats.size() == 0) begin
         report_mismatch("unexpected result word", got.cur_time_delta, '0);
      end else begin
         want = expected_stats.pop_front();
         if (got.cur_time_delta !== want.cur_time_delta)
            report_mismatch("cur_time_delta", got.cur_time_delta, want.cur_time_delta);
         if (got.cur_cycle_delta !== want.cur_cycle_delta)
            report_mismatch("cur_cycle_delta", got.cur_cycle_delta, want.cur_cycle_delta);
         if (got.avg_time_delta !== want.avg_time_delta)
            report_mismatch("avg_time_delta", got.avg_time_delta, want.avg_time_delta);
         if (got.avg_cycle_delta !== want.avg_cycle_delta)
            report_mismatch("avg_cycle_delta", got.avg_cycle_delta, want.avg_cycle_delta);
         if (got.peak_time_delta !== want.peak_time_delta)
            report_mismatch("peak_time_delta", got.peak_time_delta, want.peak_time_delta);
         if (got.peak_cycle_delta !== want.peak_cycle_delta)
            report_mismatch("peak_cycle_delta", got.peak_cycle_delta, want.peak_cycle_delta);
      end
   endtask

   function automatic data_type any_stamp();
      return {$urandom, $urandom};
   endfunction

   function automatic data_type any_span();
      int pick;
      pick = $urandom_range(9);
      if (pick < 5) return data_type'($urandom_range(1000));
      if (pick < 8) return data_type'($urandom);
      return any_stamp();
   endfunction

   task automatic queue_word(input logic [MODE_WIDTH-1:0] mode, input data_type ts,
                             input data_type cs);
      req_word_type w;
      w.mode        = mode;
      w.time_stamp  = ts;
      w.cycle_stamp = cs;
      pending_words.push_back(w);
      phase_word_count++;
   endtask

   task automatic queue_directed();
      data_type ones;
      ones = '1;
      queue_word(MODE_END, 64'd5, 64'd7);
      queue_word(MODE_BEGIN, '0, '0);
      queue_word(MODE_END, ones, ones);
      queue_word(MODE_BEGIN, ones, ones);
      queue_word(MODE_END, '0, '0);
      queue_word(MODE_UNUSED, 64'h1234, 64'h5678);
      queue_word(MODE_END, 64'd3, 64'd3);
      queue_word(MODE_CLEAR, ones, ones);
      queue_word(MODE_END, 64'd10, 64'd20);
      queue_word(MODE_BEGIN, 64'd100, 64'd200);
      for (int i = 1; i <= 10; i++)
         queue_word(MODE_END, 64'd100 + 64'(i * 37), 64'd200 + 64'(i * 1001));
      queue_word(MODE_BEGIN, 64'h8000_0000_0000_0000, 64'h7fff_ffff_ffff_ffff);
      queue_word(MODE_END, ones, 64'h8000_0000_0000_0000);
      queue_word(MODE_CLEAR, '0, '0);
   endtask

   task automatic queue_random(input int target);
      data_type ts;
      data_type cs;
      int       pick;
      while (phase_word_count < target) begin
         pick = $urandom_range(99);
         ts = any_stamp();
         cs = any_stamp();
         if (pick < 70) begin
            queue_word(MODE_BEGIN, ts, cs);
            if ($urandom_range(19) == 0) queue_word(MODE_UNUSED, any_stamp(), any_stamp());
            queue_word(MODE_END, ts + any_span(), cs + any_span());
         end else if (pick < 80) begin
            queue_word(MODE_END, ts, cs);
         end else if (pick < 88) begin
            queue_word(MODE_BEGIN, ts, cs);
         end else if (pick < 94) begin
            queue_word(MODE_CLEAR, ts, cs);
         end else begin
            queue_word(MODE_UNUSED, ts, cs);
         end
      end
   endtask

   task automatic run_phase(input int send_pct, input int recv_pct, input bit directed);
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
      phase_word_count = 0;
      if (directed) queue_directed();
      queue_random(PHASE_WORDS);
      do @(negedge clock);
      while (pending_words.size() != 0 || req_chan.valid || expected_stats.size() != 0);
   endtask

   always @(posedge clock) begin : drive_words
      req_word_type taken;
      req_word_type next_word;
      if (reset) begin
         req_chan.valid <= 1'b0;
      end else begin
         if (req_chan.valid && req_chan.ready) begin
            taken.mode        = req_chan.mode;
            taken.time_stamp  = req_chan.time_stamp;
            taken.cycle_stamp = req_chan.cycle_stamp;
            track_interval(taken);
         end
         if (!req_chan.valid || req_chan.ready) begin
            if (pending_words.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               next_word = pending_words.pop_front();
               req_chan.valid       <= 1'b1;
               req_chan.mode        <= next_word.mode;
               req_chan.time_stamp  <= next_word.time_stamp;
               req_chan.cycle_stamp <= next_word.cycle_stamp;
            end else begin
               req_chan.valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin : watch_results
      rsp_word_type got;
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            got.cur_time_delta   = rsp_chan.cur_time_delta;
            got.cur_cycle_delta  = rsp_chan.cur_cycle_delta;
            got.avg_time_delta   = rsp_chan.avg_time_delta;
            got.avg_cycle_delta  = rsp_chan.avg_cycle_delta;
            got.peak_time_delta  = rsp_chan.peak_time_delta;
            got.peak_cycle_delta = rsp_chan.peak_cycle_delta;
            check_stats(got);
         end
         rsp_chan.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   initial begin
      reset                = 1'b1;
      req_chan.valid       = 1'b0;
      req_chan.mode        = MODE_BEGIN;
      req_chan.time_stamp  = '0;
      req_chan.cycle_stamp = '0;
      rsp_chan.ready       = 1'b0;
      error_count   = 0;
      cycle_count   = 0;
      send_idle_pct = 0;
      recv_idle_pct = 0;
      slot          = 0;
      zero_stats();
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      run_phase(36, 70, 1'b1);
      run_phase(70, 36, 1'b0);
      run_phase(0, 0, 1'b0);
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (error_count == 0 && expected_stats.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

`default_nettype wire
